/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PBA_ASSERT(lbl, clk, rst_n, prop, msg)

`define PBA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/pba_pkg.sv */
// ---------------------------------------------------------------------------
// pba_pkg
// Shared widths, defaults and codes for the paged bump allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pba_pkg;

  localparam int DEF_NUM_PAGES  = 64;
  localparam int DEF_PAGE_BYTES = 2048;
  localparam int DEF_HDR_BYTES  = 32;

  localparam int KIND_W     = 2;
  localparam int OBJ_W      = 12;
  localparam int PAGE_IDX_W = 6;
  localparam int OFF_W      = 11;
  localparam int TOTAL_W    = 18;
  localparam int CAP_W      = 12;
  localparam int PAGES_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE  = 1'b1;

  localparam logic [CAP_W-1:0]   RST_CAPACITY = 12'd2008;
  localparam logic [PAGES_W-1:0] RST_PAGES    = 7'd64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_COMPACT = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_e;

endpackage

/* hdl/pba_ram.sv */
// ---------------------------------------------------------------------------
// pba_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/paged_bump_allocator.sv */
// ---------------------------------------------------------------------------
// paged_bump_allocator
// Page allocator over passive, active and compaction lists of equal pages.
// ---------------------------------------------------------------------------
// One beat in, one beat out. Page state (bump offsets and list links) sits
// in two RAMs with registered reads, so every page visited takes an address
// step and then a check step. An allocation walks the active or compaction
// list and then the passive list; when a passive page is moved, the links
// of the previous page, the list tail and the moved page are then updated.
// The lists never share a page. Finish compaction visits every active page,
// then walks the passive list to find its tail. After reset and after each
// configuration write a clearing pass over all NUM_PAGES pages rebuilds the
// heap, during which no beat is taken. A finished result waits in the
// output register while the next beat is accepted.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module paged_bump_allocator #(
  parameter int NUM_PAGES           = pba_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BYTES          = pba_pkg::DEF_PAGE_BYTES,
  parameter int OBJECT_HEADER_BYTES = pba_pkg::DEF_HDR_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pba_pkg::KIND_W-1:0]      kind_i,
  input  logic [pba_pkg::OBJ_W-1:0]       object_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic [pba_pkg::PAGE_IDX_W-1:0]  page_index_o,
  output logic [pba_pkg::OFF_W-1:0]       object_offset_o,
  output logic [pba_pkg::TOTAL_W-1:0]     used_bytes_o,
  output logic [pba_pkg::TOTAL_W-1:0]     avail_bytes_o
);

  import pba_pkg::*;

  localparam int IW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PW  = $clog2(NUM_PAGES + 1);
  localparam int PCW = $clog2(PAGE_BYTES + 1);
  localparam int CW  = (PCW > CAP_W) ? PCW : CAP_W;
  localparam int TW  = $clog2(4096 + OBJECT_HEADER_BYTES);
  localparam int SW  = ((CW > TW) ? CW : TW) + 1;
  localparam int NW  = (PW > PAGES_W) ? PW : PAGES_W;
  localparam int XW  = NW + 1;
  localparam int MW  = NW + CW;

  localparam logic [PW-1:0] LINK_NULL = PW'(NUM_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_LNK_PREV, S_LNK_TAIL, S_LNK_CUR, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LIST, PH_PASSIVE, PH_FIN_ZERO, PH_FIN_TAIL
  } phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [CAP_W-1:0]   cap_q;
  logic [PAGES_W-1:0] pages_q;

  logic [PW-1:0] active_q, passive_q, compact_q;
  logic [PW-1:0] cur_q, prev_q, tail_q, nxt_q, steps_q;
  logic          compacting_q;
  logic [TW-1:0] total_q;

  logic [TOTAL_W-1:0] used_q, avail_q;

  logic                  res_ok_q;
  logic [PAGE_IDX_W-1:0] res_page_q;
  logic [OFF_W-1:0]      res_off_q;

  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [PAGE_IDX_W-1:0] out_page_q;
  logic [OFF_W-1:0]      out_off_q;
  logic [TOTAL_W-1:0]    out_used_q, out_avail_q;

  // derived configuration
  logic [CW-1:0]      eff_cap;
  logic [NW-1:0]      eff_n;
  logic [MW-1:0]      heap_prod;
  logic [TOTAL_W-1:0] avail_init;

  assign eff_cap    = (CW'(cap_q) > CW'(PAGE_BYTES)) ? CW'(PAGE_BYTES) : CW'(cap_q);
  assign eff_n      = (NW'(pages_q) > NW'(NUM_PAGES)) ? NW'(NUM_PAGES) : NW'(pages_q);
  assign heap_prod  = MW'(eff_n) * MW'(eff_cap);
  assign avail_init = (heap_prod > MW'(TOTAL_MAX)) ? TOTAL_MAX : heap_prod[TOTAL_W-1:0];

  // page RAMs
  logic          bump_we, link_we, ram_re;
  logic [IW-1:0] bump_wa, link_wa;
  logic [CW-1:0] bump_wd, bump_rd;
  logic [PW-1:0] link_wd, link_rd;

  pba_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_bump_ram (
    .clk_i   (clk_i),
    .we_i    (bump_we),
    .waddr_i (bump_wa),
    .wdata_i (bump_wd),
    .re_i    (ram_re),
    .raddr_i (cur_q[IW-1:0]),
    .rdata_o (bump_rd)
  );

  pba_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .re_i    (ram_re),
    .raddr_i (cur_q[IW-1:0]),
    .rdata_o (link_rd)
  );

  // shared unit: bump plus size against capacity
  logic [SW-1:0]      bump_sum;
  logic               fits;
  logic [TOTAL_W:0]   used_sum;
  logic [TOTAL_W-1:0] used_next, avail_next;
  logic               cur_end, tail_more;
  logic [XW-1:0]      clr_next;

  assign bump_sum   = SW'(bump_rd) + SW'(total_q);
  assign fits       = bump_sum < SW'(eff_cap);
  assign used_sum   = (TOTAL_W + 1)'(used_q) + (TOTAL_W + 1)'(total_q);
  assign used_next  = used_sum[TOTAL_W] ? TOTAL_MAX : used_sum[TOTAL_W-1:0];
  assign avail_next = (avail_q > TOTAL_W'(total_q)) ? avail_q - TOTAL_W'(total_q) : '0;
  assign cur_end    = (cur_q >= LINK_NULL) || (steps_q >= LINK_NULL);
  assign tail_more  = (link_rd < LINK_NULL) && (steps_q < LINK_NULL);
  assign clr_next   = XW'(cur_q) + XW'(1);

  assign ram_re = (state_q == S_RD);

  always_comb begin
    bump_we = 1'b0;
    bump_wa = cur_q[IW-1:0];
    bump_wd = '0;
    link_we = 1'b0;
    link_wa = cur_q[IW-1:0];
    link_wd = LINK_NULL;
    case (state_q)
      S_CLEAR: begin
        bump_we = 1'b1;
        link_we = 1'b1;
        link_wd = (clr_next < XW'(eff_n)) ? clr_next[PW-1:0] : LINK_NULL;
      end
      S_CHK: begin
        case (phase_q)
          PH_LIST, PH_PASSIVE: begin
            bump_we = fits;
            bump_wd = bump_sum[CW-1:0];
          end
          PH_FIN_ZERO: bump_we = 1'b1;
          PH_FIN_TAIL: begin
            link_we = !tail_more;
            link_wd = active_q;
          end
          default: ;
        endcase
      end
      S_LNK_PREV: begin
        link_we = (prev_q != LINK_NULL);
        link_wa = prev_q[IW-1:0];
        link_wd = nxt_q;
      end
      S_LNK_TAIL: begin
        link_we = (tail_q != LINK_NULL);
        link_wa = tail_q[IW-1:0];
        link_wd = cur_q;
      end
      S_LNK_CUR: link_we = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      phase_q      <= PH_LIST;
      cap_q        <= RST_CAPACITY;
      pages_q      <= RST_PAGES;
      active_q     <= LINK_NULL;
      passive_q    <= LINK_NULL;
      compact_q    <= LINK_NULL;
      cur_q        <= '0;
      prev_q       <= LINK_NULL;
      tail_q       <= LINK_NULL;
      nxt_q        <= LINK_NULL;
      steps_q      <= '0;
      compacting_q <= 1'b0;
      used_q       <= '0;
      avail_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          // one page per cycle; heads and totals follow the current settings
          passive_q <= (eff_n != '0) ? '0 : LINK_NULL;
          active_q  <= LINK_NULL;
          compact_q <= LINK_NULL;
          used_q    <= '0;
          avail_q   <= avail_init;
          if (clr_next >= XW'(NUM_PAGES)) begin
            state_q <= S_IDLE;
          end else begin
            cur_q <= clr_next[PW-1:0];
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            total_q      <= TW'(object_bytes_i) + TW'(OBJECT_HEADER_BYTES);
            compacting_q <= (kind_e'(kind_i) == KIND_COMPACT);
            res_ok_q     <= 1'b0;
            res_page_q   <= '0;
            res_off_q    <= '0;
            steps_q      <= '0;
            tail_q       <= LINK_NULL;
            prev_q       <= LINK_NULL;
            case (kind_e'(kind_i))
              KIND_NORMAL: begin
                phase_q <= PH_LIST;
                cur_q   <= active_q;
                state_q <= S_RD;
              end
              KIND_COMPACT: begin
                phase_q <= PH_LIST;
                cur_q   <= compact_q;
                state_q <= S_RD;
              end
              KIND_FINISH: begin
                phase_q <= PH_FIN_ZERO;
                cur_q   <= active_q;
                state_q <= S_RD;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          if (cur_end && phase_q == PH_LIST) begin
            phase_q <= PH_PASSIVE;
            cur_q   <= passive_q;
            steps_q <= '0;
          end else if (cur_end && phase_q == PH_PASSIVE) begin
            state_q <= S_DONE;
          end else if (cur_end && phase_q == PH_FIN_ZERO) begin
            res_ok_q <= 1'b1;
            if (passive_q == LINK_NULL) begin
              passive_q <= active_q;
              active_q  <= compact_q;
              compact_q <= LINK_NULL;
              state_q   <= S_DONE;
            end else begin
              phase_q <= PH_FIN_TAIL;
              cur_q   <= passive_q;
              steps_q <= '0;
            end
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          case (phase_q)
            PH_LIST, PH_PASSIVE: begin
              if (fits) begin
                res_ok_q   <= 1'b1;
                res_page_q <= cur_q[PAGE_IDX_W-1:0];
                res_off_q  <= OFF_W'(bump_rd + CW'(OBJECT_HEADER_BYTES));
                used_q     <= used_next;
                avail_q    <= avail_next;
                nxt_q      <= link_rd;
                state_q    <= (phase_q == PH_LIST) ? S_DONE : S_LNK_PREV;
              end else begin
                if (phase_q == PH_LIST) begin
                  tail_q <= cur_q;
                end else begin
                  prev_q <= cur_q;
                end
                cur_q   <= link_rd;
                steps_q <= steps_q + PW'(1);
                state_q <= S_RD;
              end
            end
            PH_FIN_ZERO: begin
              cur_q   <= link_rd;
              steps_q <= steps_q + PW'(1);
              state_q <= S_RD;
            end
            PH_FIN_TAIL: begin
              if (tail_more) begin
                cur_q   <= link_rd;
                steps_q <= steps_q + PW'(1);
                state_q <= S_RD;
              end else begin
                active_q  <= compact_q;
                compact_q <= LINK_NULL;
                state_q   <= S_DONE;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_LNK_PREV: begin
          if (prev_q == LINK_NULL) begin
            passive_q <= nxt_q;
          end
          state_q <= S_LNK_TAIL;
        end
        S_LNK_TAIL: begin
          if (tail_q == LINK_NULL) begin
            if (compacting_q) begin
              compact_q <= cur_q;
            end else begin
              active_q <= cur_q;
            end
          end
          state_q <= S_LNK_CUR;
        end
        S_LNK_CUR: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_ok_q    <= res_ok_q;
            out_page_q  <= res_page_q;
            out_off_q   <= res_off_q;
            out_used_q  <= used_q;
            out_avail_q <= avail_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // a register write rebuilds the heap
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PAGE_CAPACITY) begin
          cap_q <= cfg_data_i[CAP_W-1:0];
        end else begin
          pages_q <= cfg_data_i[PAGES_W-1:0];
        end
        cur_q   <= '0;
        state_q <= S_CLEAR;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign page_index_o    = out_page_q;
  assign object_offset_o = out_off_q;
  assign used_bytes_o    = out_used_q;
  assign avail_bytes_o   = out_avail_q;

  `PBA_ASSERT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && !cfg_we_i |=> state_q != S_IDLE, "accepted beat did not start work")
  `PBA_ASSERT(a_steps_bound, clk_i, rst_ni, steps_q <= LINK_NULL, "walk step count beyond page count")
  `PBA_ASSERT(a_done_loads, clk_i, rst_ni, state_q == S_DONE && !out_valid_q && !cfg_we_i |=> out_valid_q, "result not loaded into free output register")

endmodule
